// File: hdl/bcm_pkg.sv
package bcm_pkg;

  localparam int VoltW    = 15;
  localparam int CurW     = 16;
  localparam int AvgW     = 32;
  localparam int AccW     = 48;
  localparam int AlphaW   = 16;
  localparam int CountW   = 8;
  localparam int PctW     = 7;
  localparam int ChargeW  = 32;
  localparam int RegIdxW  = 3;
  localparam int RegDataW = 16;

  // (v - empty) * 100 needs 22 bits; the divider retires one quotient bit a step
  localparam int NumW     = VoltW + PctW;
  localparam int DivSteps = NumW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [CountW-1:0] LowRunMax = 8'd250;
  localparam logic [PctW-1:0]   PctFull   = 7'd100;

  // register indexes
  localparam logic [RegIdxW-1:0] RegMonitorEnabled = 3'd0;
  localparam logic [RegIdxW-1:0] RegCriticalMv     = 3'd1;
  localparam logic [RegIdxW-1:0] RegNoiseFloorMv   = 3'd2;
  localparam logic [RegIdxW-1:0] RegConfirm        = 3'd3;
  localparam logic [RegIdxW-1:0] RegAlpha          = 3'd4;
  localparam logic [RegIdxW-1:0] RegEmptyMv        = 3'd5;
  localparam logic [RegIdxW-1:0] RegFullMv         = 3'd6;

  // reset values
  localparam logic                RstEnabled  = 1'b1;
  localparam logic [VoltW-1:0]    RstCritical = 15'd3100;
  localparam logic [VoltW-1:0]    RstNoise    = 15'd2000;
  localparam logic [CountW-1:0]   RstConfirm  = 8'd5;
  localparam logic [AlphaW-1:0]   RstAlpha    = 16'd3277;
  localparam logic [VoltW-1:0]    RstEmpty    = 15'd3000;
  localparam logic [VoltW-1:0]    RstFull     = 15'd4200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_AVG,
    ST_CHARGE,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;      // capture the sample
    logic mult;      // average product, percent numerator, low run
    logic avg;       // update the average
    logic charge;    // accumulate charge, arm the divider
    logic div_step;  // one restoring division step
    logic out_load;  // move results into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic critical;
  } dp_status_t;

endpackage

// File: hdl/bcm_sample_if.sv
interface bcm_sample_if;
  logic                              valid;
  logic                              ready;
  logic        [bcm_pkg::VoltW-1:0]  voltage_mv;
  logic signed [bcm_pkg::CurW-1:0]   current_ma;

  modport source (output valid, output voltage_mv, output current_ma, input ready);
  modport sink   (input valid, input voltage_mv, input current_ma, output ready);
endinterface

// File: hdl/bcm_result_if.sv
interface bcm_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcm_pkg::CurW-1:0]     avg_current_ma;
  logic signed [bcm_pkg::ChargeW-1:0]  charge_mas;
  logic        [bcm_pkg::PctW-1:0]     battery_percent;
  logic                                battery_critical;
  logic        [bcm_pkg::CountW-1:0]   low_run_count;

  modport source (output valid, output avg_current_ma, output charge_mas,
                  output battery_percent, output battery_critical,
                  output low_run_count, input ready);
  modport sink   (input valid, input avg_current_ma, input charge_mas,
                  input battery_percent, input battery_critical,
                  input low_run_count, output ready);
endinterface

// File: hdl/battery_charge_monitor.sv
// Coulomb-counting battery monitor. Each sample beat carries a bus voltage
// (mV) and a signed current (mA); with monitor_enabled low both are taken as
// zero. The current is smoothed by an exponential average in Q16 (reloaded
// from the sample when it is exactly zero), the average is added into a
// saturating 48-bit Q16 charge accumulator (mA-s), a run of consecutive low
// readings latches battery_critical once it reaches confirm_samples (only
// reset clears it), and battery_percent maps voltage linearly between
// empty_mv and full_mv, clamped to 0..100. One result beat leaves per sample
// beat. The block works one sample at a time: a sample is accepted, then come
// the alpha multiply, the average update, the charge update, the restoring
// percent division (one quotient bit a cycle) and the load of the output
// register, in that order; the next sample is accepted only once the previous
// result is loaded. The output register lets the next sample be accepted while
// a result still waits; a second result stalls in the last step until the
// first is taken. Configuration writes take effect on the next edge; write
// them only while no sample is in flight. Indexes above 6 are ignored.
module battery_charge_monitor (
  input  logic                            clk,
  input  logic                            rst,
  bcm_sample_if.sink                      sample,
  bcm_result_if.source                    result,
  input  logic                            write_en,
  input  logic [bcm_pkg::RegIdxW-1:0]     write_index,
  input  logic [bcm_pkg::RegDataW-1:0]    write_data
);
  import bcm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: walks one sample through the datapath steps
  bcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // registers, state, multiplier and divider
  bcm_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .write_en         (write_en),
    .write_index      (write_index),
    .write_data       (write_data),
    .voltage_mv       (sample.voltage_mv),
    .current_ma       (sample.current_ma),
    .cmd              (cmd),
    .status           (status),
    .avg_current_ma   (result.avg_current_ma),
    .charge_mas       (result.charge_mas),
    .battery_percent  (result.battery_percent),
    .battery_critical (result.battery_critical),
    .low_run_count    (result.low_run_count)
  );

  // critical flag never drops once latched
  a_critical_sticky: assert property (@(posedge clk) disable iff (rst)
    status.critical |=> status.critical)
    else $error("critical latch dropped");

  // a sample is worked one at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample accepted while busy");

  // results stay within their ranges
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.battery_percent <= PctFull) &&
                     (result.low_run_count <= LowRunMax))
    else $error("result field out of range");

  // the output register is loaded only when it is empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result.valid || result.ready))
    else $error("pending result overwritten");

endmodule

// File: hdl/bcm_ctrl.sv
module bcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bcm_pkg::dp_cmd_t    cmd,
  input  bcm_pkg::dp_status_t status
);
  import bcm_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg    = 1'b1;
        state_next = ST_CHARGE;
      end
      ST_CHARGE: begin
        cmd.charge = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = out_full;
    priority if (cmd.out_load) out_full_next = 1'b1;
    else if (out_ready)        out_full_next = 1'b0;
    else                       out_full_next = out_full;
  end

endmodule

// File: hdl/bcm_datapath.sv
module bcm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_en,
  input  logic        [bcm_pkg::RegIdxW-1:0]  write_index,
  input  logic        [bcm_pkg::RegDataW-1:0] write_data,
  input  logic        [bcm_pkg::VoltW-1:0]    voltage_mv,
  input  logic signed [bcm_pkg::CurW-1:0]     current_ma,
  input  bcm_pkg::dp_cmd_t                    cmd,
  output bcm_pkg::dp_status_t                 status,
  output logic signed [bcm_pkg::CurW-1:0]     avg_current_ma,
  output logic signed [bcm_pkg::ChargeW-1:0]  charge_mas,
  output logic        [bcm_pkg::PctW-1:0]     battery_percent,
  output logic                                battery_critical,
  output logic        [bcm_pkg::CountW-1:0]   low_run_count
);
  import bcm_pkg::*;

  localparam int DiffW = AvgW + 1;
  localparam int ProdW = DiffW + AlphaW + 1;
  localparam int SumW  = AccW + 1;

  // configuration
  logic              monitor_enabled;
  logic [VoltW-1:0]  critical_threshold_mv;
  logic [VoltW-1:0]  noise_floor_mv;
  logic [CountW-1:0] confirm_samples;
  logic [AlphaW-1:0] current_alpha_q16;
  logic [VoltW-1:0]  empty_mv;
  logic [VoltW-1:0]  full_mv;

  // state
  logic signed [AvgW-1:0] avg_q16;
  logic signed [AccW-1:0] acc_q16;
  logic [CountW-1:0]      low_count;
  logic                   critical_latch;

  // work registers
  logic [VoltW-1:0]        volt;
  logic signed [CurW-1:0]  cur;
  logic signed [ProdW-1:0] prod;
  logic [NumW-1:0]         div_q;
  logic [VoltW-1:0]        div_r;
  logic [VoltW-1:0]        div_den;
  logic [DivCntW-1:0]      div_cnt;
  logic                    pct_zero;
  logic                    pct_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enabled       <= RstEnabled;
      critical_threshold_mv <= RstCritical;
      noise_floor_mv        <= RstNoise;
      confirm_samples       <= RstConfirm;
      current_alpha_q16     <= RstAlpha;
      empty_mv              <= RstEmpty;
      full_mv               <= RstFull;
    end else if (write_en) begin
      unique case (write_index)
        RegMonitorEnabled: monitor_enabled       <= write_data[0];
        RegCriticalMv:     critical_threshold_mv <= write_data[VoltW-1:0];
        RegNoiseFloorMv:   noise_floor_mv        <= write_data[VoltW-1:0];
        RegConfirm:        confirm_samples       <= write_data[CountW-1:0];
        RegAlpha:          current_alpha_q16     <= write_data[AlphaW-1:0];
        RegEmptyMv:        empty_mv              <= write_data[VoltW-1:0];
        RegFullMv:         full_mv               <= write_data[VoltW-1:0];
        default: ;
      endcase
    end
  end

  // averaging
  logic signed [AvgW-1:0]  target;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-DiffW-1:0] alpha_s;
  logic signed [ProdW-16-1:0] step;
  logic signed [ProdW-16-1:0] avg_sum;

  assign target  = {cur, 16'b0};
  assign diff    = DiffW'(target) - DiffW'(avg_q16);
  assign alpha_s = {1'b0, current_alpha_q16};
  assign step    = prod[ProdW-1:16];  // floor by 2^16
  assign avg_sum = step + (ProdW-16)'(avg_q16);

  // charge
  logic signed [SumW-1:0] acc_sum;
  logic signed [AccW-1:0] acc_sat;

  assign acc_sum = SumW'(acc_q16) + SumW'(avg_q16);
  always_comb begin
    if (acc_sum[SumW-1] != acc_sum[SumW-2])
      acc_sat = acc_sum[SumW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    else
      acc_sat = acc_sum[AccW-1:0];
  end

  // low run
  logic              is_low;
  logic [CountW-1:0] low_next;

  assign is_low = monitor_enabled && (volt > noise_floor_mv) && (volt < critical_threshold_mv);
  always_comb begin
    if (!is_low)                low_next = '0;
    else if (low_count < LowRunMax) low_next = low_count + 1'b1;
    else                        low_next = low_count;
  end

  // percent numerator and divider step
  logic [VoltW-1:0] dv;
  logic [VoltW:0]   div_rs;
  logic             div_ge;

  assign dv     = volt - empty_mv;
  assign div_rs = {div_r, div_q[NumW-1]};
  assign div_ge = div_rs >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_q16        <= '0;
      acc_q16        <= '0;
      low_count      <= '0;
      critical_latch <= 1'b0;
    end else begin
      if (cmd.mult) begin
        low_count <= low_next;
        if (low_next >= confirm_samples) critical_latch <= 1'b1;
      end
      if (cmd.avg) begin
        if (avg_q16 == '0) avg_q16 <= target;
        else               avg_q16 <= avg_sum[AvgW-1:0];
      end
      if (cmd.charge) acc_q16 <= acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      volt <= monitor_enabled ? voltage_mv : '0;
      cur  <= monitor_enabled ? current_ma : '0;
    end
    if (cmd.mult) begin
      prod     <= diff * alpha_s;
      div_q    <= NumW'(dv) * NumW'(PctFull);
      div_den  <= full_mv - empty_mv;
      pct_zero <= volt <= empty_mv;
      pct_full <= full_mv <= empty_mv;
    end
    if (cmd.charge) begin
      div_r   <= '0;
      div_cnt <= DivCntW'(DivSteps - 1);
    end
    if (cmd.div_step) begin
      div_r   <= div_ge ? VoltW'(div_rs - {1'b0, div_den}) : div_rs[VoltW-1:0];
      div_q   <= {div_q[NumW-2:0], div_ge};
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.out_load) begin
      avg_current_ma   <= avg_q16[AvgW-1:16];
      charge_mas       <= acc_q16[AccW-1:16];
      battery_critical <= critical_latch;
      low_run_count    <= low_count;
      priority if (pct_zero)          battery_percent <= '0;
      else if (pct_full)              battery_percent <= PctFull;
      else if (div_q > NumW'(PctFull)) battery_percent <= PctFull;
      else                            battery_percent <= div_q[PctW-1:0];
    end
  end

  assign status.div_last = div_cnt == '0;
  assign status.critical = critical_latch;

endmodule
